@@ hw/rtl/typed_page_frame_allocator_macros.svh @@
// assertion macros shared by the page frame allocator rtl
// depends on nothing; included inside module bodies after the package import
`ifndef TYPED_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define TYPED_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TPFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define TPFA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tpfa_pkg.sv @@
// shared types, codes and sizing constants of the page frame allocator
// depends on nothing
`default_nettype none

package tpfa_pkg;

  // pool sizing; a page of the type map holds PAGE_BYTES entries (power of two)
  localparam int MAX_PAGES    = 4096;
  localparam int PAGE_BYTES   = 4096;
  localparam int PAGE_W       = $clog2(MAX_PAGES);
  localparam int COUNT_W      = $clog2(MAX_PAGES + 1);
  localparam int PB_SHIFT     = $clog2(PAGE_BYTES);
  localparam int RESET_USABLE = MAX_PAGES - (MAX_PAGES + PAGE_BYTES - 1) / PAGE_BYTES;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [2:0] {
    MODE_INIT = 3'd0,
    MODE_DATA = 3'd1,
    MODE_PDIR = 3'd2,
    MODE_PTAB = 3'd3,
    MODE_FREE = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    FREEPAGE = 2'd0,
    DATAPAGE = 2'd1,
    PDIRPAGE = 2'd2,
    PTABPAGE = 2'd3
  } page_type_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PTR_HINT  = 2'd0,
    PTR_TOP   = 2'd1,
    PTR_INDEX = 2'd2
  } ptr_src_t;

  typedef enum logic [1:0] {
    HINT_KEEP    = 2'd0,
    HINT_PTR     = 2'd1,
    HINT_PTR_INC = 2'd2,
    HINT_MIN_PTR = 2'd3
  } hint_op_t;

  typedef enum logic [2:0] {
    S_RST_CLEAR  = 3'd0,
    S_IDLE       = 3'd1,
    S_INIT_CLEAR = 3'd2,
    S_SCAN_RD    = 3'd3,
    S_SCAN_CHK   = 3'd4,
    S_READ       = 3'd5,
    S_CHK        = 3'd6,
    S_DONE       = 3'd7
  } tpfa_state_t;

  typedef struct packed {
    logic       capture;
    logic       do_init;
    ptr_src_t   ptr_src;
    logic       clr_step;
    logic       rd_en;
    logic       wr_en;
    page_type_t wr_type;
    logic       ptr_inc;
    logic       set_status;
    status_t    status_val;
    logic       grant;
    logic       free_dec;
    logic       free_inc;
    logic       top_dec;
    hint_op_t   hint_op;
    logic       load_out;
  } tpfa_cmd_t;

  typedef struct packed {
    logic       idx_ok;
    logic       top_ok;
    logic       ptr_end;
    logic       clr_last;
    page_type_t rd_type;
    logic       out_busy;
  } tpfa_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/tpfa_ram.sv @@
// generic single write port, single read port ram with registered read
// depends on nothing
`default_nettype none

module tpfa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tpfa_ctrl.sv @@
// controller state machine of the page frame allocator
// depends on tpfa_pkg and typed_page_frame_allocator_macros.svh
`default_nettype none

module tpfa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           in_mode,
  input  wire tpfa_pkg::tpfa_sts_t  sts,
  output tpfa_pkg::tpfa_cmd_t       cmd
);
  import tpfa_pkg::*;
  `include "typed_page_frame_allocator_macros.svh"

  tpfa_state_t state_r, state_nxt;
  mode_t       mode_r, mode_nxt;
  logic        accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    mode_nxt = accept ? mode_t'(in_mode) : mode_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RST_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_INIT_CLEAR: begin
        if (sts.clr_last) state_nxt = S_DONE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_INIT:            state_nxt = S_INIT_CLEAR;
            MODE_DATA, MODE_PDIR: state_nxt = S_SCAN_RD;
            MODE_PTAB:            state_nxt = sts.top_ok ? S_READ : S_DONE;
            MODE_FREE:            state_nxt = sts.idx_ok ? S_READ : S_DONE;
            default:              state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN_RD: begin
        state_nxt = sts.ptr_end ? S_DONE : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.rd_type == PTABPAGE || sts.rd_type == FREEPAGE) state_nxt = S_DONE;
        else state_nxt = S_SCAN_RD;
      end
      S_READ: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_RST_CLEAR, S_INIT_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.capture    = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status_val = ST_OK;
          unique case (in_mode)
            MODE_INIT: begin
              cmd.do_init = 1'b1;
            end
            MODE_DATA, MODE_PDIR: begin
              cmd.ptr_src    = PTR_HINT;
              cmd.status_val = ST_OOM;
            end
            MODE_PTAB: begin
              cmd.ptr_src = PTR_TOP;
              if (!sts.top_ok) cmd.status_val = ST_OOM;
            end
            MODE_FREE: begin
              cmd.ptr_src = PTR_INDEX;
              if (!sts.idx_ok) cmd.status_val = ST_RANGE;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (sts.ptr_end) cmd.hint_op = HINT_PTR;
        else cmd.rd_en = 1'b1;
      end
      S_SCAN_CHK: begin
        priority if (sts.rd_type == PTABPAGE) begin
          cmd.hint_op = HINT_PTR;
        end else if (sts.rd_type == FREEPAGE) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_type    = (mode_r == MODE_DATA) ? DATAPAGE : PDIRPAGE;
          cmd.free_dec   = 1'b1;
          cmd.grant      = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status_val = ST_OK;
          cmd.hint_op    = HINT_PTR_INC;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
      end
      S_CHK: begin
        if (mode_r == MODE_PTAB) begin
          if (sts.rd_type == FREEPAGE) begin
            cmd.wr_en    = 1'b1;
            cmd.wr_type  = PTABPAGE;
            cmd.grant    = 1'b1;
            cmd.top_dec  = 1'b1;
            cmd.free_dec = 1'b1;
            cmd.hint_op  = HINT_MIN_PTR;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status_val = ST_OOM;
          end
        end else begin
          if (sts.rd_type == FREEPAGE) begin
            cmd.set_status = 1'b1;
            cmd.status_val = ST_DOUBLE;
          end else begin
            cmd.wr_en    = 1'b1;
            cmd.wr_type  = FREEPAGE;
            cmd.free_inc = 1'b1;
            cmd.hint_op  = HINT_MIN_PTR;
          end
        end
      end
      S_DONE: begin
        cmd.load_out = !sts.out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RST_CLEAR;
      mode_r  <= MODE_INIT;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  `TPFA_ASSERT_NXT(a_init_goes_to_clear, clk, rst_n, accept && in_mode == MODE_INIT, state_r == S_INIT_CLEAR, "init request did not start the map clear")
  `TPFA_ASSERT_IMP(a_scan_check_after_read, clk, rst_n, state_r == S_SCAN_CHK, $past(cmd.rd_en), "scan check without a read issued the cycle before")

endmodule

`default_nettype wire

@@ hw/rtl/tpfa_dpath.sv @@
// datapath of the page frame allocator: type map, counters, pointers, result register
// depends on tpfa_pkg, tpfa_ram and typed_page_frame_allocator_macros.svh
`default_nettype none

module tpfa_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [tpfa_pkg::COUNT_W-1:0]    cfg_wdata,
  input  wire logic [tpfa_pkg::PAGE_W-1:0]     in_page_index,
  input  wire tpfa_pkg::tpfa_cmd_t             cmd,
  output tpfa_pkg::tpfa_sts_t                  sts,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [tpfa_pkg::PAGE_W-1:0]          out_granted_page,
  output logic [1:0]                           out_status,
  output logic [tpfa_pkg::COUNT_W-1:0]         out_free_count
);
  import tpfa_pkg::*;
  `include "typed_page_frame_allocator_macros.svh"

  count_t  mem_pages_r, mem_pages_nxt;
  count_t  usable_r, usable_nxt;
  count_t  free_r, free_nxt;
  count_t  top_r, top_nxt;
  count_t  hint_r, hint_nxt;
  count_t  ptr_r, ptr_nxt;
  page_t   clr_r, clr_nxt;
  page_t   granted_r, granted_nxt;
  status_t status_r, status_nxt;
  logic    out_valid_r, out_valid_nxt;
  page_t   out_granted_r, out_granted_nxt;
  status_t out_status_r, out_status_nxt;
  count_t  out_free_r, out_free_nxt;

  // usable page count from the configured size
  count_t          total;
  logic [COUNT_W:0] ovh_sum;
  count_t          overhead;
  count_t          usable_calc;

  logic            ram_we;
  page_t           ram_waddr;
  logic [1:0]      ram_wdata;
  logic [1:0]      ram_rdata;

  always_comb begin
    if (mem_pages_r < COUNT_W'(2)) total = COUNT_W'(2);
    else if (mem_pages_r > COUNT_W'(MAX_PAGES)) total = COUNT_W'(MAX_PAGES);
    else total = mem_pages_r;
    ovh_sum     = {1'b0, total} + (COUNT_W+1)'(PAGE_BYTES - 1);
    overhead    = COUNT_W'(ovh_sum >> PB_SHIFT);
    usable_calc = total - overhead;
  end

  // type map
  assign ram_we    = cmd.wr_en || cmd.clr_step;
  assign ram_waddr = cmd.clr_step ? clr_r : ptr_r[PAGE_W-1:0];
  assign ram_wdata = cmd.clr_step ? FREEPAGE : cmd.wr_type;

  tpfa_ram #(
    .WIDTH (2),
    .DEPTH (MAX_PAGES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (ptr_r[PAGE_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.idx_ok   = {1'b0, in_page_index} < usable_r;
    sts.top_ok   = top_r < usable_r;
    sts.ptr_end  = ptr_r >= usable_r;
    sts.clr_last = clr_r == PAGE_W'(MAX_PAGES - 1);
    sts.rd_type  = page_type_t'(ram_rdata);
    sts.out_busy = out_valid_r && !out_ready;
  end

  always_comb begin
    mem_pages_nxt   = cfg_we ? cfg_wdata : mem_pages_r;
    usable_nxt      = usable_r;
    free_nxt        = free_r;
    top_nxt         = top_r;
    hint_nxt        = hint_r;
    ptr_nxt         = ptr_r;
    clr_nxt         = clr_r;
    granted_nxt     = granted_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    out_free_nxt    = out_free_r;

    if (cmd.capture) begin
      granted_nxt = '0;
      unique case (cmd.ptr_src)
        PTR_HINT:  ptr_nxt = hint_r;
        PTR_TOP:   ptr_nxt = top_r;
        PTR_INDEX: ptr_nxt = {1'b0, in_page_index};
        default:   ptr_nxt = hint_r;
      endcase
    end
    if (cmd.do_init) begin
      usable_nxt = usable_calc;
      free_nxt   = usable_calc;
      top_nxt    = usable_calc - COUNT_W'(1);
      hint_nxt   = '0;
      clr_nxt    = '0;
    end
    if (cmd.clr_step) clr_nxt = clr_r + PAGE_W'(1);
    if (cmd.ptr_inc)  ptr_nxt = ptr_r + COUNT_W'(1);
    if (cmd.set_status) status_nxt = cmd.status_val;
    if (cmd.grant)    granted_nxt = ptr_r[PAGE_W-1:0];
    if (cmd.free_dec) free_nxt = free_r - COUNT_W'(1);
    if (cmd.free_inc) free_nxt = free_r + COUNT_W'(1);
    // wraps past the bottom once page zero is taken, which reads as out of range
    if (cmd.top_dec)  top_nxt = top_r - COUNT_W'(1);

    // every page below the hint holds data or a directory
    unique case (cmd.hint_op)
      HINT_KEEP:    ;
      HINT_PTR:     hint_nxt = ptr_r;
      HINT_PTR_INC: hint_nxt = ptr_r + COUNT_W'(1);
      HINT_MIN_PTR: if (ptr_r < hint_r) hint_nxt = ptr_r;
      default:      ;
    endcase

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) begin
      out_valid_nxt   = 1'b1;
      out_granted_nxt = granted_r;
      out_status_nxt  = status_r;
      out_free_nxt    = free_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_pages_r <= COUNT_W'(MAX_PAGES);
      usable_r    <= COUNT_W'(RESET_USABLE);
      free_r      <= COUNT_W'(RESET_USABLE);
      top_r       <= COUNT_W'(RESET_USABLE - 1);
      hint_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mem_pages_r <= mem_pages_nxt;
      usable_r    <= usable_nxt;
      free_r      <= free_nxt;
      top_r       <= top_nxt;
      hint_r      <= hint_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r         <= ptr_nxt;
    granted_r     <= granted_nxt;
    status_r      <= status_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
    out_free_r    <= out_free_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted_page = out_granted_r;
  assign out_status       = out_status_r;
  assign out_free_count   = out_free_r;

  `TPFA_ASSERT_IMP(a_free_within_usable, clk, rst_n, 1'b1, free_r <= usable_r, "free count exceeds usable pages")
  `TPFA_ASSERT_IMP(a_hint_within_usable, clk, rst_n, 1'b1, hint_r <= usable_r, "scan hint beyond usable pages")
  `TPFA_ASSERT_IMP(a_no_take_when_empty, clk, rst_n, cmd.free_dec, free_r != '0, "page taken while free count is zero")

endmodule

`default_nettype wire

@@ hw/rtl/typed_page_frame_allocator.sv @@
// Typed page frame allocator. Keeps a 2-bit type (free, data, directory, table) for
// every page in a MAX_PAGES-entry type map held in one ram, and serves one request
// per input item with one result. After reset, and after every init request, the
// block sweeps the whole map to free at one entry per cycle and takes no request
// while it sweeps; the init result is loaded once the sweep ends. Table and free
// requests go through one map read, one check and write, and one result load; a free
// with an index past the usable pages, a table request whose pointer has run off
// the bottom and a reserved mode go straight from the accept to the result load.
// Data and directory requests scan upward through the map, one read and one check
// per page, starting at a hint register that skips the run of data and directory
// pages at the bottom of the pool, and stop at the first free page, at a table page
// or at the end of the usable pages. Requests are handled one at a time and the
// block is back in idle the cycle after the result load; the result sits in an
// output register, so the next request is accepted while the previous result still
// waits for out_ready, and the one after that waits until the first result is taken.
// depends on tpfa_pkg, tpfa_ctrl and tpfa_dpath
`default_nettype none

module typed_page_frame_allocator (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration: memory_pages
  input  wire logic                         cfg_we,
  input  wire logic [tpfa_pkg::COUNT_W-1:0] cfg_wdata,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [2:0]                   in_mode,
  input  wire logic [tpfa_pkg::PAGE_W-1:0]  in_page_index,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [tpfa_pkg::PAGE_W-1:0]       out_granted_page,
  output logic [1:0]                        out_status,
  output logic [tpfa_pkg::COUNT_W-1:0]      out_free_count
);
  import tpfa_pkg::*;

  // command and status between the sequencer and the map datapath
  tpfa_cmd_t cmd;
  tpfa_sts_t sts;

  // sequencer: decodes the request, steps the clear sweep and the upward scan
  tpfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: type map ram, free count, table pointer, scan hint and result register
  tpfa_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_page_index    (in_page_index),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_page (out_granted_page),
    .out_status       (out_status),
    .out_free_count   (out_free_count)
  );

endmodule

`default_nettype wire
